[rtl/urc_pkg.sv]
package urc_pkg;

	localparam int TIMEOUT_W  = 20;
	localparam int INTERVAL_W = 16;
	localparam int IDLE_W     = 17;
	localparam int PULSE_W    = 20;
	localparam int CNT_W      = 4;
	localparam int DIST_W     = 18;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	// conversion datapath
	localparam int SCALED_W = 24;                  // w*10 + bias
	localparam int NUM_W    = 23;                  // dividend after the power-of-two part
	localparam int RECIP_W  = 24;
	localparam int PROD_W   = NUM_W + RECIP_W;

	localparam logic [CNT_W-1:0]      TRIG_LOW_US  = 4'd2;
	localparam logic [CNT_W-1:0]      TRIG_HIGH_US = 4'd10;
	localparam logic [IDLE_W-1:0]     IDLE_MAX     = '1;
	localparam logic [PULSE_W-1:0]    PULSE_MAX    = '1;
	localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 20'd20000;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd2000;

	// cm: (10w+28)/56 = ((10w+28)>>3)/7 ; inch: (10w+71)/142 = ((10w+71)>>1)/71
	localparam logic [4:0]         BIAS_CM   = 5'd28;
	localparam logic [6:0]         BIAS_INCH = 7'd71;
	localparam logic [6:0]         DIV_CM    = 7'd7;
	localparam logic [6:0]         DIV_INCH  = 7'd71;
	localparam logic [RECIP_W-1:0] RECIP_CM   = 24'd2396745;   // floor(2^24/7)
	localparam logic [RECIP_W-1:0] RECIP_INCH = 24'd15123124;  // floor(2^30/71)

	typedef enum logic [5:0] {
		PH_IDLE      = 6'b000001,
		PH_TRIG_LOW  = 6'b000010,
		PH_TRIG_HIGH = 6'b000100,
		PH_WAIT_LOW  = 6'b001000,
		PH_WAIT_RISE = 6'b010000,
		PH_MEASURE   = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		REG_UNIT_INCH    = 2'd0,
		REG_ECHO_TIMEOUT = 2'd1,
		REG_INTERVAL     = 2'd2
	} cfg_reg_t;

	// flags that ride alongside the conversion
	typedef struct packed {
		logic trig;
		logic done;
		logic tmo;
	} res_flags_t;

endpackage

[rtl/urc_item_if.sv]
interface urc_item_if;
	logic valid;
	logic ready;
	logic echo_level;
	logic ms_strobe;

	modport source (output valid, output echo_level, output ms_strobe, input ready);
	modport sink (input valid, input echo_level, input ms_strobe, output ready);
endinterface

[rtl/urc_result_if.sv]
interface urc_result_if;
	import urc_pkg::*;

	logic              valid;
	logic              ready;
	logic              trigger_level;
	logic              result_valid;
	logic [DIST_W-1:0] distance_tenths;
	logic              timed_out;

	modport source (output valid, output trigger_level, output result_valid,
		output distance_tenths, output timed_out, input ready);
	modport sink (input valid, input trigger_level, input result_valid,
		input distance_tenths, input timed_out, output ready);
endinterface

[rtl/urc_convert.sv]
module urc_convert (
	input  logic                         clk,
	input  logic                         en_s2,
	input  logic [urc_pkg::PULSE_W-1:0]  width_s1,
	input  logic                         inch_s1,
	output logic [urc_pkg::DIST_W-1:0]   quot
);
	import urc_pkg::*;

	logic [SCALED_W-1:0] scaled;
	logic [NUM_W-1:0]    num;
	logic [RECIP_W-1:0]  recip;

	logic [PROD_W-1:0]   prod_s2;
	logic [NUM_W-1:0]    num_s2;
	logic                inch_s2;

	logic [DIST_W-1:0]   q_est;
	logic [6:0]          divisor;
	logic [NUM_W-1:0]    rem;

	always_comb begin
		scaled = SCALED_W'(width_s1) * SCALED_W'(10)
			+ (inch_s1 ? SCALED_W'(BIAS_INCH) : SCALED_W'(BIAS_CM));
		num    = inch_s1 ? scaled[SCALED_W-1:1] : {2'b00, scaled[SCALED_W-1:3]};
		recip  = inch_s1 ? RECIP_INCH : RECIP_CM;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= PROD_W'(num) * PROD_W'(recip);
			num_s2  <= num;
			inch_s2 <= inch_s1;
		end
	end

	// estimate is exact or one short, a single correction step fixes it
	always_comb begin
		q_est   = inch_s2 ? DIST_W'(prod_s2[PROD_W-1:30]) : prod_s2[41:24];
		divisor = inch_s2 ? DIV_INCH : DIV_CM;
		rem     = num_s2 - NUM_W'(q_est * divisor);
		quot    = (rem >= NUM_W'(divisor)) ? q_est + DIST_W'(1) : q_est;
	end

endmodule

[rtl/ultrasonic_range_controller.sv]
// ultrasonic rangefinder echo timer
// item_in carries one transaction per microsecond tick: the sampled echo pin
// level and a millisecond strobe. every accepted tick yields exactly one
// transaction on result_out: the trigger pin level for that tick, plus a
// result_valid flag, distance in tenths of cm or inch and a timeout flag on
// the tick a measurement completes.
// the tick control updates in the cycle of acceptance; the result leaves
// through a three-register pipeline (flags, reciprocal multiply, output), so
// it is presented from the output register. one tick is taken every cycle
// while the pipeline is not stalled; the tick control's next state is
// combinational and every later stage is registered.
// when the receiver stalls, each stage holds only if it is occupied, so
// bubbles are absorbed and item_in.ready drops once all stages are full.
// the apb port holds unit_inch (0x0), echo_timeout_us (0x4) and
// interval_ms (0x8); pready is always high and writes complete in the
// access cycle. arst_n clears the phase, counters and the pipeline valid
// bits and restores the register reset values.
module ultrasonic_range_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	urc_item_if.sink                     item_in,
	urc_result_if.source                 result_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [urc_pkg::ADDR_W-1:0]   paddr,
	input  logic [urc_pkg::DATA_W-1:0]   pwdata,
	output logic [urc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import urc_pkg::*;

	// configuration
	logic                  unit_inch_q;
	logic [TIMEOUT_W-1:0]  timeout_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic                  cfg_wr;

	// control state
	phase_t                phase_q, phase_d;
	logic [IDLE_W-1:0]     idle_q, idle_d, idle_inc;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [TIMEOUT_W-1:0]  elapsed_q, elapsed_d;
	logic [PULSE_W-1:0]    pulse_q, pulse_d;
	res_flags_t            flags;
	logic [PULSE_W-1:0]    width;

	// pipeline
	logic                  in_acc;
	logic                  en_s1, en_s2, en_out;
	logic                  v_s1, v_s2;
	res_flags_t            flags_s1, flags_s2;
	logic [PULSE_W-1:0]    width_s1;
	logic                  inch_s1;
	logic [DIST_W-1:0]     quot;

	logic                  out_v_q;
	logic                  trig_q;
	logic                  done_q;
	logic [DIST_W-1:0]     dist_q;
	logic                  tmo_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_inch_q <= 1'b0;
			timeout_q   <= TIMEOUT_RST;
			interval_q  <= INTERVAL_RST;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(paddr[3:2]))
				REG_UNIT_INCH:    unit_inch_q <= pwdata[0];
				REG_ECHO_TIMEOUT: timeout_q   <= pwdata[TIMEOUT_W-1:0];
				REG_INTERVAL:     interval_q  <= pwdata[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_reg_t'(paddr[3:2]))
			REG_UNIT_INCH:    prdata = DATA_W'(unit_inch_q);
			REG_ECHO_TIMEOUT: prdata = DATA_W'(timeout_q);
			REG_INTERVAL:     prdata = DATA_W'(interval_q);
			default:          prdata = '0;
		endcase
	end

	// per-tick control
	always_comb begin
		phase_d   = phase_q;
		idle_d    = idle_q;
		cnt_d     = cnt_q;
		elapsed_d = elapsed_q;
		pulse_d   = pulse_q;
		flags     = '0;
		width     = '0;
		idle_inc  = (item_in.ms_strobe && idle_q != IDLE_MAX) ? idle_q + IDLE_W'(1) : idle_q;

		unique case (phase_q)
			PH_TRIG_LOW: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_d >= TRIG_LOW_US) begin
					phase_d = PH_TRIG_HIGH;
					cnt_d   = '0;
				end
			end
			PH_TRIG_HIGH: begin
				flags.trig = 1'b1;
				cnt_d      = cnt_q + CNT_W'(1);
				if (cnt_d >= TRIG_HIGH_US) begin
					phase_d   = PH_WAIT_LOW;
					cnt_d     = '0;
					elapsed_d = '0;
					pulse_d   = '0;
				end
			end
			PH_WAIT_LOW, PH_WAIT_RISE, PH_MEASURE: begin
				if (elapsed_q >= timeout_q) begin
					// echo level ignored on the timeout tick
					flags.done = 1'b1;
					flags.tmo  = 1'b1;
					phase_d    = PH_IDLE;
				end else begin
					elapsed_d = elapsed_q + TIMEOUT_W'(1);
					if (phase_q == PH_WAIT_LOW) begin
						if (!item_in.echo_level) phase_d = PH_WAIT_RISE;
					end else if (phase_q == PH_WAIT_RISE) begin
						if (item_in.echo_level) begin
							phase_d = PH_MEASURE;
							pulse_d = PULSE_W'(1);
						end
					end else if (item_in.echo_level) begin
						if (pulse_q != PULSE_MAX) pulse_d = pulse_q + PULSE_W'(1);
					end else begin
						flags.done = 1'b1;
						width      = pulse_q;
						phase_d    = PH_IDLE;
					end
				end
			end
			default: begin
				// idle, and any stray code behaves as idle
				phase_d = PH_IDLE;
				idle_d  = idle_inc;
				if (idle_inc > IDLE_W'(interval_q)) begin
					idle_d  = '0;
					phase_d = PH_TRIG_LOW;
					cnt_d   = '0;
				end
			end
		endcase
	end

	assign en_out        = !out_v_q || result_out.ready;
	assign en_s2         = !v_s2 || en_out;
	assign en_s1         = !v_s1 || en_s2;
	assign item_in.ready = en_s1;
	assign in_acc        = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			idle_q    <= '0;
			cnt_q     <= '0;
			elapsed_q <= '0;
			pulse_q   <= '0;
		end else if (in_acc) begin
			phase_q   <= phase_d;
			idle_q    <= idle_d;
			cnt_q     <= cnt_d;
			elapsed_q <= elapsed_d;
			pulse_q   <= pulse_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1    <= item_in.valid;
			if (en_s2)  v_s2    <= v_s1;
			if (en_out) out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			flags_s1 <= flags;
			width_s1 <= width;
			inch_s1  <= unit_inch_q;
		end
		if (en_s2) flags_s2 <= flags_s1;
		if (en_out) begin
			trig_q <= flags_s2.trig;
			done_q <= flags_s2.done;
			tmo_q  <= flags_s2.tmo;
			dist_q <= (flags_s2.done && !flags_s2.tmo) ? quot : '0;
		end
	end

	urc_convert u_convert (
		.clk      (clk),
		.en_s2    (en_s2),
		.width_s1 (width_s1),
		.inch_s1  (inch_s1),
		.quot     (quot)
	);

	assign result_out.valid           = out_v_q;
	assign result_out.trigger_level   = trig_q;
	assign result_out.result_valid    = done_q;
	assign result_out.distance_tenths = dist_q;
	assign result_out.timed_out       = tmo_q;

endmodule

[rtl/urc_checker.sv]
module urc_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       trigger_level,
	input  logic                       result_valid,
	input  logic [urc_pkg::DIST_W-1:0] distance_tenths,
	input  logic                       timed_out
);
	import urc_pkg::*;

	// stalled transaction keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_tenths)
			&& $stable(result_valid) && $stable(timed_out) && $stable(trigger_level))
		else $error("result transaction changed while stalled");

	// no result fields without a completed measurement
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_valid |-> !timed_out && distance_tenths == '0)
		else $error("result fields set without result_valid");

	// timeout always reports zero distance
	a_tmo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> result_valid && distance_tenths == '0)
		else $error("timeout with non-zero distance");

	// a measurement never completes while the trigger is driven high
	a_trig_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger_level |-> !result_valid)
		else $error("result during trigger pulse");

endmodule

bind ultrasonic_range_controller urc_checker u_urc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (result_out.valid),
	.out_ready       (result_out.ready),
	.trigger_level   (result_out.trigger_level),
	.result_valid    (result_out.result_valid),
	.distance_tenths (result_out.distance_tenths),
	.timed_out       (result_out.timed_out)
);

[sim/urc_tb_pkg.sv]
package urc_tb_pkg;

	import urc_pkg::*;

	typedef struct packed {
		logic              trig;
		logic              done;
		logic [DIST_W-1:0] distance;
		logic              tmo;
	} tick_result_t;

	class range_scoreboard;

		logic                  unit_inch;
		logic [TIMEOUT_W-1:0]  echo_timeout;
		logic [INTERVAL_W-1:0] interval;

		logic [IDLE_W-1:0]     idle_ms;
		phase_t                ph;
		logic [CNT_W-1:0]      ph_us;
		logic [TIMEOUT_W-1:0]  elapsed;
		logic [PULSE_W-1:0]    pulse_us;

		tick_result_t expected_ticks[$];
		int n_done;
		int n_timeouts;
		int n_checked;
		int n_mismatch;

		function new();
			unit_inch    = 1'b0;
			echo_timeout = TIMEOUT_RST;
			interval     = INTERVAL_RST;
			idle_ms      = '0;
			ph           = PH_IDLE;
			ph_us        = '0;
			elapsed      = '0;
			pulse_us     = '0;
			n_done       = 0;
			n_timeouts   = 0;
			n_checked    = 0;
			n_mismatch   = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [DATA_W-1:0] v);
			case (r)
				REG_UNIT_INCH:    unit_inch = v[0];
				REG_ECHO_TIMEOUT: echo_timeout = v[TIMEOUT_W-1:0];
				REG_INTERVAL:     interval = v[INTERVAL_W-1:0];
				default: ;
			endcase
		endfunction

		function bit in_echo_phase();
			return ph == PH_WAIT_LOW || ph == PH_WAIT_RISE || ph == PH_MEASURE;
		endfunction

		function bit is_idle();
			return ph == PH_IDLE;
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction

		// rounded half up in tenths of the selected unit
		function logic [DIST_W-1:0] to_tenths(logic [PULSE_W-1:0] w);
			longint unsigned x;
			x = 64'(w) * 10;
			if (unit_inch)
				x = (x + 71) / 142;
			else
				x = (x + 28) / 56;
			return DIST_W'(x);
		endfunction

		function tick_result_t predict_tick(logic echo, logic strobe);
			tick_result_t r;
			r = '0;
			case (ph)
				PH_TRIG_LOW: begin
					ph_us = ph_us + 1'b1;
					if (ph_us >= TRIG_LOW_US) begin
						ph    = PH_TRIG_HIGH;
						ph_us = '0;
					end
				end
				PH_TRIG_HIGH: begin
					r.trig = 1'b1;
					ph_us  = ph_us + 1'b1;
					if (ph_us >= TRIG_HIGH_US) begin
						ph       = PH_WAIT_LOW;
						ph_us    = '0;
						elapsed  = '0;
						pulse_us = '0;
					end
				end
				PH_WAIT_LOW, PH_WAIT_RISE, PH_MEASURE: begin
					// timeout wins over the echo level of this tick
					if (elapsed >= echo_timeout) begin
						r.done = 1'b1;
						r.tmo  = 1'b1;
						ph     = PH_IDLE;
					end else begin
						elapsed = elapsed + 1'b1;
						if (ph == PH_WAIT_LOW) begin
							if (!echo)
								ph = PH_WAIT_RISE;
						end else if (ph == PH_WAIT_RISE) begin
							if (echo) begin
								ph       = PH_MEASURE;
								pulse_us = PULSE_W'(1);
							end
						end else if (echo) begin
							if (pulse_us != PULSE_MAX)
								pulse_us = pulse_us + 1'b1;
						end else begin
							r.done     = 1'b1;
							r.distance = to_tenths(pulse_us);
							ph         = PH_IDLE;
						end
					end
				end
				default: begin
					ph = PH_IDLE;
					if (strobe && idle_ms != IDLE_MAX)
						idle_ms = idle_ms + 1'b1;
					if (idle_ms > IDLE_W'(interval)) begin
						idle_ms = '0;
						ph      = PH_TRIG_LOW;
						ph_us   = '0;
					end
				end
			endcase
			return r;
		endfunction

		function void note_tick(logic echo, logic strobe);
			tick_result_t r;
			r = predict_tick(echo, strobe);
			if (r.done)
				n_done++;
			if (r.tmo)
				n_timeouts++;
			expected_ticks.push_back(r);
		endfunction

		function void check_result(tick_result_t got);
			tick_result_t want;
			if (expected_ticks.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("[%0t] result transaction with nothing expected: trig=%0b valid=%0b dist=%0d tmo=%0b",
						$time, got.trig, got.done, got.distance, got.tmo);
				return;
			end
			want = expected_ticks.pop_front();
			n_checked++;
			if (got.trig !== want.trig || got.done !== want.done ||
					got.distance !== want.distance || got.tmo !== want.tmo) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("[%0t] mismatch: exp trig=%0b valid=%0b dist=%0d tmo=%0b, got trig=%0b valid=%0b dist=%0d tmo=%0b",
						$time, want.trig, want.done, want.distance, want.tmo,
						got.trig, got.done, got.distance, got.tmo);
			end
		endfunction

	endclass

endpackage

[sim/tb_ultrasonic_range_controller.sv]
module tb_ultrasonic_range_controller;

	timeunit 1ns;
	timeprecision 1ps;

	import urc_pkg::*;
	import urc_tb_pkg::*;

	localparam int HUGE = 1 << 20;

	typedef struct {
		int pre_high;
		int low_len;
		int width;
		bit noise;
	} echo_plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic src_valid = 1'b0;
	logic src_echo = 1'b0;
	logic src_strobe = 1'b0;
	logic sink_ready = 1'b0;

	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	urc_item_if   item ();
	urc_result_if res ();

	assign item.valid      = src_valid;
	assign item.echo_level = src_echo;
	assign item.ms_strobe  = src_strobe;
	assign res.ready       = sink_ready;

	ultrasonic_range_controller dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item),
		.result_out (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	range_scoreboard sb = new();

	int src_idle_pct = 17;
	int sink_idle_pct = 59;
	int strobe_pct = 100;
	int ticks_sent = 0;
	int n_settings = 0;

	echo_plan_t plan_q[$];
	echo_plan_t plan;
	bit plan_live = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		sink_ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		tick_result_t got;
		if (arst_n && res.valid && res.ready) begin
			got.trig     = res.trigger_level;
			got.done     = res.result_valid;
			got.distance = res.distance_tenths;
			got.tmo      = res.timed_out;
			sb.check_result(got);
		end
	end

	function echo_plan_t make_plan(int pre_high, int low_len, int width, bit noise);
		echo_plan_t p;
		p.pre_high = pre_high;
		p.low_len  = low_len;
		p.width    = width;
		p.noise    = noise;
		return p;
	endfunction

	// mostly clean pulses with random timing, some noisy echoes
	function echo_plan_t random_plan();
		int w;
		if ($urandom_range(99) < 15)
			return make_plan(0, 0, 0, 1'b1);
		if ($urandom_range(99) < 5)
			w = $urandom_range(400, 150);
		else
			w = $urandom_range(40, 1);
		return make_plan(($urandom_range(1) != 0) ? $urandom_range(3, 1) : 0,
			$urandom_range(10, 1), w, 1'b0);
	endfunction

	function logic next_echo();
		if (plan.noise)
			return logic'($urandom_range(1));
		if (plan.pre_high > 0) begin
			plan.pre_high--;
			return 1'b1;
		end
		if (plan.low_len > 0) begin
			plan.low_len--;
			return 1'b0;
		end
		if (plan.width > 0) begin
			plan.width--;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// send ticks until n_meas measurements have finished, n_ticks ticks are sent and the timer is idle
	task automatic drive_ticks(int n_meas, int n_ticks);
		int done_start;
		int sent;
		bit finished;
		done_start = sb.n_done;
		sent = 0;
		finished = 1'b0;
		while (!finished) begin
			@(posedge clk);
			if (src_valid && item.ready) begin
				sb.note_tick(src_echo, src_strobe);
				sent++;
				ticks_sent++;
			end
			if (!(src_valid && !item.ready)) begin
				if (sb.n_done - done_start >= n_meas && sent >= n_ticks && sb.is_idle()) begin
					src_valid <= 1'b0;
					finished = 1'b1;
				end else if ($urandom_range(99) < src_idle_pct) begin
					src_valid <= 1'b0;
				end else begin
					if (sb.in_echo_phase()) begin
						if (!plan_live) begin
							plan = (plan_q.size() != 0) ? plan_q.pop_front() : random_plan();
							plan_live = 1'b1;
						end
						src_echo   <= next_echo();
						src_strobe <= logic'($urandom_range(1));
					end else begin
						plan_live = 1'b0;
						src_echo   <= logic'($urandom_range(1));
						src_strobe <= ($urandom_range(99) < strobe_pct);
					end
					src_valid <= 1'b1;
				end
			end
		end
	endtask

	task automatic wait_drain();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(cfg_reg_t r, logic [DATA_W-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(r, v);
	endtask

	initial begin
		#20_000_000;
		$display("timeout: %0d result transactions still expected", sb.pending());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int errors;
		int timeout_val;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: the 2000 ms interval keeps the timer idle
		strobe_pct = 100;
		drive_ticks(0, 30);
		wait_drain();

		apb_write(REG_UNIT_INCH, 1);
		apb_write(REG_ECHO_TIMEOUT, 1000000);
		apb_write(REG_INTERVAL, 0);
		n_settings++;
		strobe_pct = 60;
		plan_q.push_back(make_plan(0, 1, 1, 1'b0));
		plan_q.push_back(make_plan(0, 2, 15, 1'b0));
		plan_q.push_back(make_plan(1, 4, 100, 1'b0));
		drive_ticks(3, 0);
		wait_drain();

		// zero timeout ends on the first echo tick
		apb_write(REG_UNIT_INCH, 0);
		apb_write(REG_ECHO_TIMEOUT, 0);
		n_settings++;
		plan_q.push_back(make_plan(0, 1, 5, 1'b0));
		drive_ticks(1, 0);
		wait_drain();

		apb_write(REG_ECHO_TIMEOUT, 1);
		n_settings++;
		plan_q.push_back(make_plan(0, 1, 5, 1'b0));
		drive_ticks(1, 0);
		wait_drain();

		// timeouts while measuring, waiting for the rise and waiting for low
		apb_write(REG_ECHO_TIMEOUT, 20);
		n_settings++;
		plan_q.push_back(make_plan(0, 1, HUGE, 1'b0));
		plan_q.push_back(make_plan(0, HUGE, 0, 1'b0));
		plan_q.push_back(make_plan(HUGE, 0, 0, 1'b0));
		plan_q.push_back(make_plan(0, 3, 12, 1'b0));
		drive_ticks(4, 0);
		wait_drain();

		// widest interval never fires within a short run
		apb_write(REG_INTERVAL, 65535);
		n_settings++;
		strobe_pct = 100;
		drive_ticks(0, 30);
		wait_drain();

		for (int s = 0; s < 6; s++) begin
			if (s < 2) begin
				src_idle_pct  = 17;
				sink_idle_pct = 59;
			end else if (s < 4) begin
				src_idle_pct  = 59;
				sink_idle_pct = 17;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			case ($urandom_range(3))
				0: timeout_val = 1000000;
				1: timeout_val = 1;
				2: timeout_val = $urandom_range(150, 30);
				default: timeout_val = 20000;
			endcase
			apb_write(REG_UNIT_INCH, $urandom_range(1));
			apb_write(REG_ECHO_TIMEOUT, timeout_val);
			apb_write(REG_INTERVAL, $urandom_range(4));
			n_settings++;
			strobe_pct = $urandom_range(100, 30);
			drive_ticks(1, 20);
			wait_drain();
		end

		errors = sb.n_mismatch + sb.pending();
		if (sb.pending() != 0)
			$display("%0d expected result transactions never arrived", sb.pending());
		$display("covered %0d ticks, %0d result transactions checked, %0d register settings",
			ticks_sent, sb.n_checked, n_settings);
		$display("measurements completed: %0d, of which %0d by timeout; %0d mismatches",
			sb.n_done, sb.n_timeouts, sb.n_mismatch);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[ultrasonic_range_controller.f]
rtl/urc_pkg.sv
rtl/urc_item_if.sv
rtl/urc_result_if.sv
rtl/urc_convert.sv
rtl/ultrasonic_range_controller.sv
rtl/urc_checker.sv
sim/urc_tb_pkg.sv
sim/tb_ultrasonic_range_controller.sv
